// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/occd_pkg.sv =====
// Shared types and command codes of the OLED command/data core.
// No dependencies.
`default_nettype none
package occd_pkg;

   localparam int FRAME_BYTES = 1024;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int Q_DEPTH     = 2;
   localparam int QPTR_W      = $clog2(Q_DEPTH);
   localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] CMD_COL_WINDOW  = 8'h21;
   localparam logic [7:0] CMD_PAGE_WINDOW = 8'h22;
   localparam logic [7:0] CMD_ADDR_MODE   = 8'h20;
   localparam logic [7:0] CMD_CONTRAST    = 8'h81;
   localparam logic [7:0] CMD_CHARGE_PUMP = 8'h8D;
   localparam logic [7:0] CMD_MUX_RATIO   = 8'hA8;
   localparam logic [7:0] CMD_OFFSET      = 8'hD3;
   localparam logic [7:0] CMD_CLOCK_DIV   = 8'hD5;
   localparam logic [7:0] CMD_PRECHARGE   = 8'hD9;
   localparam logic [7:0] CMD_COM_PINS    = 8'hDA;
   localparam logic [7:0] CMD_VCOM_LEVEL  = 8'hDB;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;
   localparam logic [7:0] CMD_COL_LO_MAX  = 8'h0F;
   localparam logic [7:0] CMD_COL_HI_MIN  = 8'h10;
   localparam logic [7:0] CMD_COL_HI_MAX  = 8'h1F;
   localparam logic [7:0] CMD_PAGE_MIN    = 8'hB0;
   localparam logic [7:0] CMD_PAGE_MAX    = 8'hB7;

   localparam logic [6:0] COL_LAST_RESET  = 7'h7F;
   localparam logic [2:0] PAGE_LAST_RESET = 3'h7;

   typedef enum logic [3:0] {
      OP_SKIP,     // chip not selected
      OP_DATA,     // display data byte
      OP_COL_LO,   // low column nibble
      OP_COL_HI,   // high column nibble
      OP_PAGE,     // page select
      OP_WINDOW,   // column or page window, two arguments
      OP_ARG1,     // known command with one argument
      OP_OFF,      // display off
      OP_ON,       // display on
      OP_NOP       // ignored command
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data_byte;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/occd_front.sv =====
// Front end: takes requests and classifies each byte into an operation.
// Depends on occd_pkg.
`default_nettype none
module occd_front (
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [7:0]            req_spi_byte,
   input  wire                   req_is_data,
   input  wire                   req_chip_select_n,
   input  occd_pkg::q_status_type q_status,
   output logic                  push,
   output occd_pkg::op_type      push_op
);
   import occd_pkg::*;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_op.data_byte = req_spi_byte;
      if (req_chip_select_n) begin
         push_op.kind = OP_SKIP;
      end else if (req_is_data) begin
         push_op.kind = OP_DATA;
      end else begin
         unique case (req_spi_byte) inside
            [8'h00:CMD_COL_LO_MAX]:          push_op.kind = OP_COL_LO;
            [CMD_COL_HI_MIN:CMD_COL_HI_MAX]: push_op.kind = OP_COL_HI;
            [CMD_PAGE_MIN:CMD_PAGE_MAX]:     push_op.kind = OP_PAGE;
            CMD_COL_WINDOW, CMD_PAGE_WINDOW: push_op.kind = OP_WINDOW;
            CMD_ADDR_MODE, CMD_CONTRAST, CMD_CHARGE_PUMP, CMD_MUX_RATIO,
            CMD_OFFSET, CMD_CLOCK_DIV, CMD_PRECHARGE, CMD_COM_PINS,
            CMD_VCOM_LEVEL:                  push_op.kind = OP_ARG1;
            CMD_DISPLAY_OFF:                 push_op.kind = OP_OFF;
            CMD_DISPLAY_ON:                  push_op.kind = OP_ON;
            default:                         push_op.kind = OP_NOP;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/occd_queue.sv =====
// Two-entry operation queue between front and back end.
// Depends on occd_pkg.
`default_nettype none
module occd_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  occd_pkg::op_type       push_op,
   input  wire                    pop,
   output occd_pkg::op_type       pop_op,
   output occd_pkg::q_status_type q_status
);
   import occd_pkg::*;

   op_type              entries_ff [Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == QCNT_W'(Q_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_op         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/occd_back.sv =====
// Back end: executes operations on the pointer/window state, drives the result register.
// Depends on occd_pkg.
`default_nettype none
module occd_back (
   input  wire                           clock,
   input  wire                           reset,
   input  occd_pkg::q_status_type        q_status,
   input  occd_pkg::op_type              pop_op,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic                          rsp_fb_write,
   output logic [occd_pkg::ADDR_W-1:0]   rsp_fb_address,
   output logic [7:0]                    rsp_fb_data,
   output logic                          rsp_frame_done,
   output logic                          rsp_panel_on
);
   import occd_pkg::*;

   logic [7:0] col_ff, col_in;
   logic [2:0] page_ff, page_in;
   logic [6:0] col_first_ff, col_first_in;
   logic [6:0] col_last_ff, col_last_in;
   logic [2:0] page_first_ff, page_first_in;
   logic [2:0] page_last_ff, page_last_in;
   logic [7:0] held_ff, held_in;
   logic [1:0] args_left_ff, args_left_in;
   logic [1:0] arg_idx_ff, arg_idx_in;
   logic       panel_ff, panel_in;

   logic              valid_ff, valid_in;
   logic              wr_ff, wr_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        data_ff, data_in;
   logic              done_ff, done_in;

   logic [7:0] col_inc;
   logic [7:0] b;

   assign pop = !q_status.empty && (!valid_ff || rsp_ready);
   assign b   = pop_op.data_byte;

   always_comb begin
      col_in        = col_ff;
      page_in       = page_ff;
      col_first_in  = col_first_ff;
      col_last_in   = col_last_ff;
      page_first_in = page_first_ff;
      page_last_in  = page_last_ff;
      held_in       = held_ff;
      args_left_in  = args_left_ff;
      arg_idx_in    = arg_idx_ff;
      panel_in      = panel_ff;
      wr_in         = 1'b0;
      addr_in       = '0;
      data_in       = '0;
      done_in       = 1'b0;
      col_inc       = col_ff + 8'd1;

      if (pop_op.kind == OP_DATA) begin
         if (!col_ff[7]) begin
            wr_in   = 1'b1;
            addr_in = {page_ff, col_ff[6:0]};
            data_in = b;
         end
         col_in = col_inc;
         if (col_inc > {1'b0, col_last_ff}) begin
            col_in = {1'b0, col_first_ff};
            if (page_ff >= page_last_ff) begin
               page_in = page_first_ff;
               done_in = 1'b1;
            end else begin
               page_in = page_ff + 3'd1;
            end
         end
      end else if (pop_op.kind != OP_SKIP && args_left_ff != 2'd0) begin
         // any command byte is an argument while arguments are pending
         args_left_in = args_left_ff - 2'd1;
         if (held_ff == CMD_COL_WINDOW) begin
            if (arg_idx_ff == 2'd0) begin
               col_first_in = b[6:0];
               col_in       = {1'b0, b[6:0]};
            end else begin
               col_last_in = b[6:0];
            end
            arg_idx_in = arg_idx_ff + 2'd1;
         end else if (held_ff == CMD_PAGE_WINDOW) begin
            if (arg_idx_ff == 2'd0) begin
               page_first_in = b[2:0];
               page_in       = b[2:0];
            end else begin
               page_last_in = b[2:0];
            end
            arg_idx_in = arg_idx_ff + 2'd1;
         end
      end else begin
         unique case (pop_op.kind)
            OP_COL_LO: col_in  = {col_ff[7:4], b[3:0]};
            OP_COL_HI: col_in  = {b[3:0], col_ff[3:0]};
            OP_PAGE:   page_in = b[2:0];
            OP_WINDOW: begin
               held_in      = b;
               args_left_in = 2'd2;
               arg_idx_in   = 2'd0;
            end
            OP_ARG1: begin
               held_in      = b;
               args_left_in = 2'd1;
               arg_idx_in   = 2'd0;
            end
            OP_OFF:    panel_in = 1'b0;
            OP_ON:     panel_in = 1'b1;
            default:   ;
         endcase
      end

      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         page_ff       <= '0;
         col_first_ff  <= '0;
         col_last_ff   <= COL_LAST_RESET;
         page_first_ff <= '0;
         page_last_ff  <= PAGE_LAST_RESET;
         held_ff       <= '0;
         args_left_ff  <= '0;
         arg_idx_ff    <= '0;
         panel_ff      <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            col_ff        <= col_in;
            page_ff       <= page_in;
            col_first_ff  <= col_first_in;
            col_last_ff   <= col_last_in;
            page_first_ff <= page_first_in;
            page_last_ff  <= page_last_in;
            held_ff       <= held_in;
            args_left_ff  <= args_left_in;
            arg_idx_ff    <= arg_idx_in;
            panel_ff      <= panel_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (pop) begin
         wr_ff   <= wr_in;
         addr_ff <= addr_in;
         data_ff <= data_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_fb_write   = wr_ff;
   assign rsp_fb_address = addr_ff;
   assign rsp_fb_data    = data_ff;
   assign rsp_frame_done = done_ff;
   // panel flag after this byte; the state only moves on a pop
   assign rsp_panel_on   = panel_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/oled_controller_command_and_data_core.sv =====
// OLED command/data core top level: front decoder, two-entry queue, back executor.
// Depends on occd_pkg, occd_front, occd_queue, occd_back.
// Path: an accepted request is queued, then popped by the back end into the response register.
// Throughput: one request per cycle while the response channel is not stalled.
// Reset: synchronous; window is full screen, pointers zero, display off, queue empty.
`default_nettype none
module oled_controller_command_and_data_core (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [7:0]                   req_spi_byte,
   input  wire                          req_is_data,
   input  wire                          req_chip_select_n,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_fb_write,
   output logic [occd_pkg::ADDR_W-1:0]  rsp_fb_address,
   output logic [7:0]                   rsp_fb_data,
   output logic                         rsp_frame_done,
   output logic                         rsp_panel_on
);
   import occd_pkg::*;

   q_status_type q_status;
   logic         push;
   logic         pop;
   op_type       push_op;
   op_type       pop_op;

   // Front: classifies each request by byte value alone; whether a command
   // byte is really an argument is decided in the back end, which owns the
   // pending-argument count.
   occd_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_spi_byte      (req_spi_byte),
      .req_is_data       (req_is_data),
      .req_chip_select_n (req_chip_select_n),
      .q_status          (q_status),
      .push              (push),
      .push_op           (push_op)
   );

   // Queue: two entries let the front take one more request
   // while the response register is stalled.
   occd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_op  (push_op),
      .pop      (pop),
      .pop_op   (pop_op),
      .q_status (q_status)
   );

   // Back: pointer, window and argument state; one operation per cycle
   // into the response register while it is not stalled.
   occd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_op         (pop_op),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_fb_write   (rsp_fb_write),
      .rsp_fb_address (rsp_fb_address),
      .rsp_fb_data    (rsp_fb_data),
      .rsp_frame_done (rsp_frame_done),
      .rsp_panel_on   (rsp_panel_on)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/occd_checker.sv =====
// Port-level checker for the OLED command/data core, bound to the top level.
// Depends on occd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module occd_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire                         rsp_fb_write,
   input wire [occd_pkg::ADDR_W-1:0]  rsp_fb_address,
   input wire [7:0]                   rsp_fb_data
);
   import occd_pkg::*;

   // a response without a write carries zero address and data
   `ASSERT_CLK(a_nowrite_zero, clock, reset, (rsp_valid && !rsp_fb_write) |-> (rsp_fb_address == '0 && rsp_fb_data == '0), "non-write response has nonzero payload")

   // no response is pending right after reset
   `ASSERT_CLK_ALL(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

   // a stalled response holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_fb_address) && $stable(rsp_fb_data)), "stalled response changed")

endmodule

bind oled_controller_command_and_data_core occd_checker u_occd_checker (.*);
`default_nettype wire

// ===== test/occd_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Frame-buffer write predictor and response scoreboard for the OLED command/data core.
// Depends on occd_pkg for command codes and the address width.
package occd_scoreboard_pkg;
   import occd_pkg::*;

   typedef struct packed {
      logic              fb_write;
      logic [ADDR_W-1:0] fb_address;
      logic [7:0]        fb_data;
      logic              frame_done;
      logic              panel_on;
   } fb_response_type;

   class fb_write_scoreboard;
      // shadow of the core's addressing state
      logic [7:0] column_ptr;
      logic [2:0] page_ptr;
      logic [6:0] col_first;
      logic [6:0] col_last;
      logic [2:0] page_first;
      logic [2:0] page_last;
      logic [7:0] held_cmd;
      logic [1:0] args_left;
      logic [1:0] arg_index;
      logic       panel_en;

      fb_response_type expected_writes[$];
      int unsigned     failures;

      function new();
         column_ptr = '0;
         page_ptr   = '0;
         col_first  = '0;
         col_last   = COL_LAST_RESET;
         page_first = '0;
         page_last  = PAGE_LAST_RESET;
         held_cmd   = '0;
         args_left  = '0;
         arg_index  = '0;
         panel_en   = 1'b0;
         failures   = 0;
      endfunction

      function int unsigned outstanding();
         return expected_writes.size();
      endfunction

      // Predict the response to one accepted request and queue it.
      function void note_request(logic [7:0] b, logic is_data, logic cs_n);
         fb_response_type r;
         r = '0;
         if (!cs_n) begin
            if (is_data) begin
               if (!column_ptr[7]) begin
                  r.fb_write   = 1'b1;
                  r.fb_address = {page_ptr, column_ptr[6:0]};
                  r.fb_data    = b;
               end
               column_ptr = column_ptr + 8'd1;
               if (column_ptr > {1'b0, col_last}) begin
                  column_ptr = {1'b0, col_first};
                  if (page_ptr >= page_last) begin
                     page_ptr     = page_first;
                     r.frame_done = 1'b1;
                  end else begin
                     page_ptr = page_ptr + 3'd1;
                  end
               end
            end else if (args_left != 2'd0) begin
               // any command byte is an argument while one is pending
               args_left = args_left - 2'd1;
               if (held_cmd == CMD_COL_WINDOW) begin
                  if (arg_index == 2'd0) begin
                     col_first  = b[6:0];
                     column_ptr = {1'b0, b[6:0]};
                  end else begin
                     col_last = b[6:0];
                  end
                  arg_index = arg_index + 2'd1;
               end else if (held_cmd == CMD_PAGE_WINDOW) begin
                  if (arg_index == 2'd0) begin
                     page_first = b[2:0];
                     page_ptr   = b[2:0];
                  end else begin
                     page_last = b[2:0];
                  end
                  arg_index = arg_index + 2'd1;
               end
            end else if (b <= CMD_COL_LO_MAX) begin
               column_ptr = {column_ptr[7:4], b[3:0]};
            end else if (b <= CMD_COL_HI_MAX) begin
               column_ptr = {b[3:0], column_ptr[3:0]};
            end else if (b >= CMD_PAGE_MIN && b <= CMD_PAGE_MAX) begin
               page_ptr = b[2:0];
            end else begin
               case (b)
                  CMD_COL_WINDOW, CMD_PAGE_WINDOW: begin
                     held_cmd  = b;
                     args_left = 2'd2;
                     arg_index = 2'd0;
                  end
                  CMD_ADDR_MODE, CMD_CONTRAST, CMD_CHARGE_PUMP, CMD_MUX_RATIO, CMD_OFFSET,
                  CMD_CLOCK_DIV, CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOM_LEVEL: begin
                     held_cmd  = b;
                     args_left = 2'd1;
                     arg_index = 2'd0;
                  end
                  CMD_DISPLAY_OFF: panel_en = 1'b0;
                  CMD_DISPLAY_ON:  panel_en = 1'b1;
                  default: ;
               endcase
            end
         end
         r.panel_on = panel_en;
         expected_writes.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            failures++;
         end
      endfunction

      function void check_response(fb_response_type act);
         fb_response_type exp_r;
         if (expected_writes.size() == 0) begin
            $display("%0t: unexpected response: actual 0x%0h", $time, act);
            failures++;
            return;
         end
         exp_r = expected_writes.pop_front();
         compare_field("fb_write",   exp_r.fb_write,   act.fb_write);
         compare_field("fb_address", exp_r.fb_address, act.fb_address);
         compare_field("fb_data",    exp_r.fb_data,    act.fb_data);
         compare_field("frame_done", exp_r.frame_done, act.frame_done);
         compare_field("panel_on",   exp_r.panel_on,   act.panel_on);
      endfunction
   endclass

endpackage

// ===== test/oled_controller_command_and_data_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the OLED command/data core: directed and random byte streams, checked
// against a predictor. Depends on occd_pkg, occd_scoreboard_pkg and the core RTL.
module oled_controller_command_and_data_core_tb;
   import occd_pkg::*;
   import occd_scoreboard_pkg::*;

   localparam int CYCLE_LIMIT    = 200_000;
   localparam int PHASE_REQUESTS = 240;

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_ready;
   logic [7:0]        req_spi_byte      = 8'h00;
   logic              req_is_data       = 1'b0;
   logic              req_chip_select_n = 1'b1;
   logic              rsp_valid;
   logic              rsp_ready         = 1'b0;
   logic              rsp_fb_write;
   logic [ADDR_W-1:0] rsp_fb_address;
   logic [7:0]        rsp_fb_data;
   logic              rsp_frame_done;
   logic              rsp_panel_on;

   // idle odds in percent, changed per phase
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   // selected requests sent so far; deselected bytes do not count
   int unsigned selected_sent  = 0;
   int unsigned cycle_count    = 0;

   // one-argument commands, each swallows the next command byte
   logic [7:0] one_arg_codes [9] = '{CMD_ADDR_MODE, CMD_CONTRAST, CMD_CHARGE_PUMP,
                                     CMD_MUX_RATIO, CMD_OFFSET, CMD_CLOCK_DIV,
                                     CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOM_LEVEL};

   fb_write_scoreboard sb = new();

   oled_controller_command_and_data_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_spi_byte      (req_spi_byte),
      .req_is_data       (req_is_data),
      .req_chip_select_n (req_chip_select_n),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fb_write      (rsp_fb_write),
      .rsp_fb_address    (rsp_fb_address),
      .rsp_fb_data       (rsp_fb_data),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_panel_on      (rsp_panel_on)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Run guard: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver back-pressure, odds set by the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Handshake monitor. Values read here are the ones from before the edge, so a
   // request and a response accepted at the same edge are seen as the core saw them.
   // The request is noted first; its response can only come at a later edge anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_spi_byte, req_is_data, req_chip_select_n);
         if (rsp_valid && rsp_ready)
            sb.check_response('{rsp_fb_write, rsp_fb_address, rsp_fb_data,
                                rsp_frame_done, rsp_panel_on});
      end
   end

   // Present one request and hold it until accepted. Entered and left at a clock
   // edge, so valid gets a single assignment per time step.
   task automatic send_request(input logic [7:0] b, input logic is_data, input logic cs_n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_spi_byte      <= b;
      req_is_data       <= is_data;
      req_chip_select_n <= cs_n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!cs_n) selected_sent++;
   endtask

   task automatic send_cmd(input logic [7:0] b);
      // occasional deselected byte slipped in between real traffic
      if ($urandom_range(99) < 8)
         send_request(8'($urandom), 1'($urandom), 1'b1);
      send_request(b, 1'b0, 1'b0);
   endtask

   task automatic send_data(input logic [7:0] b);
      send_request(b, 1'b1, 1'b0);
   endtask

   // Sender goes quiet until every outstanding response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // One random command or data sequence. Windows are kept narrow most of the time
   // so column wrap, page step and frame completion come up often.
   task automatic random_sequence();
      logic [7:0] first_arg;
      logic [6:0] span;
      int unsigned burst;
      case ($urandom_range(9))
         0: begin
            first_arg = 8'($urandom);
            span      = 7'($urandom_range(12));
            send_cmd(CMD_COL_WINDOW);
            send_cmd(first_arg);
            if ($urandom_range(3) == 0)
               send_cmd(8'($urandom));
            else
               send_cmd({1'($urandom), first_arg[6:0] + span});
         end
         1: begin
            send_cmd(CMD_PAGE_WINDOW);
            send_cmd(8'($urandom));
            send_cmd(8'($urandom));
         end
         2: send_cmd(CMD_PAGE_MIN | 8'($urandom_range(7)));
         3: begin
            if ($urandom_range(1)) begin
               send_cmd(CMD_COL_LO_MAX & 8'($urandom));
               send_cmd(CMD_COL_HI_MIN | (CMD_COL_LO_MAX & 8'($urandom)));
            end else begin
               send_cmd(CMD_COL_HI_MIN | (CMD_COL_LO_MAX & 8'($urandom)));
               send_cmd(CMD_COL_LO_MAX & 8'($urandom));
            end
         end
         4, 5, 6: begin
            burst = $urandom_range(24, 1);
            repeat (burst) send_data(8'($urandom));
         end
         7: begin
            send_cmd(one_arg_codes[$urandom_range(8)]);
            if ($urandom_range(3) == 0) send_data(8'($urandom));
            send_cmd(8'($urandom));
         end
         8: send_cmd($urandom_range(1) ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF);
         default: send_cmd(8'($urandom));
      endcase
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      send_data(8'h00);                          // first write lands at address 0
      send_request(CMD_DISPLAY_ON, 1'b0, 1'b1);  // deselected: panel stays off
      send_cmd(CMD_DISPLAY_ON);
      // last byte of the screen: write at 1023, wrap column and page, frame done
      send_cmd(CMD_PAGE_MAX);
      send_cmd(CMD_COL_LO_MAX);
      send_cmd(CMD_COL_HI_MIN | 8'h07);
      send_data(8'hA5);
      // column 240: no write, wraps to 0 and steps the page
      send_cmd(CMD_COL_HI_MAX);
      send_data(8'hFF);
      // column 128: no write, then past the window end so the page steps
      send_cmd(CMD_COL_HI_MIN | 8'h08);
      send_data(8'h5A);
      // narrow windows; top bits of the arguments are masked off
      send_cmd(CMD_COL_WINDOW);
      send_cmd(8'h85);
      send_cmd(8'h06);
      send_cmd(CMD_PAGE_WINDOW);
      send_cmd(8'hFE);
      send_cmd(8'h07);
      repeat (4) send_data(8'($urandom));
      // pending argument: data still written, display-off byte taken as argument
      send_cmd(CMD_CONTRAST);
      send_data(8'h3C);
      send_cmd(CMD_DISPLAY_OFF);
      send_cmd(CMD_DISPLAY_OFF);
      send_cmd(8'hE3);                            // unknown command, ignored
      send_cmd(CMD_DISPLAY_ON);
      drain_responses();

      // --- random part, four idle/stall phases ---
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         while (selected_sent < PHASE_REQUESTS * (phase + 1) + 25)
            random_sequence();
         drain_responses();
      end

      // let any stragglers come in before the final check
      repeat (4) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
